// ===== hdl/lkv_pkg.sv =====
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int RANK_W  = IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/lkv_if.sv =====
`timescale 1ns / 1ps

interface lkv_req_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic signed [lkv_pkg::KEY_W-1:0] key;
  logic signed [lkv_pkg::VAL_W-1:0] value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic signed [lkv_pkg::VAL_W-1:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lkv_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lkv_pkg::CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake     word
// req_i     in   valid/ready   operation, key, value
// rsp_o     out  valid/ready   hit, read_value
// cfg_i     in   valid/ready   data (capacity, always ready)
//
// words are handled one at a time, from the accept through these steps back to idle:
// the key scan walks the key ram through its single read port, one entry a cycle,
// then the decide, update and response load steps follow, in that order.
// reset clears valid bits, ranks and occupancy at once; key and value rams are not cleared.
// a response waiting on rsp_o holds the block in its last step, the next word is taken after.

module lru_key_value_cache (
  input  logic       clk_i,
  input  logic       rst_ni,
  lkv_req_if.sink    req_i,
  lkv_rsp_if.source  rsp_o,
  lkv_cfg_if.sink    cfg_i
);

  localparam int IDX_W  = lkv_pkg::IDX_W;
  localparam int RANK_W = lkv_pkg::RANK_W;
  localparam int CNT_W  = lkv_pkg::CNT_W;
  localparam int CMP_W  = lkv_pkg::CMP_W;

  lkv_pkg::state_e state_q, state_d;

  logic [lkv_pkg::CAP_W-1:0] cap_q;
  logic [CNT_W-1:0]          occ_q, occ_d;
  logic [lkv_pkg::ENTRIES-1:0] valid_q, valid_d;
  logic [RANK_W-1:0]         rank_q [lkv_pkg::ENTRIES];
  logic [RANK_W-1:0]         rank_d [lkv_pkg::ENTRIES];

  logic                      op_q;
  logic [lkv_pkg::KEY_W-1:0] key_q;
  logic [lkv_pkg::VAL_W-1:0] val_q;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;

  logic              found_q, found_d;
  logic [IDX_W-1:0]  hit_slot_q, hit_slot_d;
  logic              any_q, any_d;
  logic [RANK_W-1:0] best_q, best_d;
  logic [IDX_W-1:0]  old_slot_q, old_slot_d;
  logic              free_found_q, free_found_d;
  logic [IDX_W-1:0]  free_slot_q, free_slot_d;

  logic                      pend_hit_q, pend_hit_d;
  logic [lkv_pkg::VAL_W-1:0] pend_val_q, pend_val_d;
  logic                      rsp_valid_q, rsp_valid_d;
  logic                      rsp_hit_q, rsp_hit_d;
  logic [lkv_pkg::VAL_W-1:0] rsp_val_q, rsp_val_d;

  logic                      req_fire;
  logic                      rsp_free;
  logic                      scan_last;
  logic                      evict;
  logic [CMP_W-1:0]          cap_ext, eff_cap;
  logic [IDX_W-1:0]          tgt_slot;

  logic                      key_we, val_we, load_rsp, do_update;
  logic [lkv_pkg::KEY_W-1:0] key_rdata;
  logic [lkv_pkg::VAL_W-1:0] val_rdata;

  assign req_fire  = req_i.valid && req_i.ready;
  assign rsp_free  = !rsp_valid_q || rsp_o.ready;
  assign scan_last = (cnt_q == CNT_W'(lkv_pkg::ENTRIES));

  // capacity zero acts as one, above the table size it saturates
  assign cap_ext = CMP_W'(cap_q);
  assign eff_cap = (cap_ext == '0) ? CMP_W'(1) :
                   ((cap_ext > CMP_W'(lkv_pkg::ENTRIES)) ? CMP_W'(lkv_pkg::ENTRIES) : cap_ext);
  assign evict   = (CMP_W'(occ_q) >= eff_cap) && (occ_q != '0);
  assign tgt_slot = found_q ? hit_slot_q : (evict ? old_slot_q : free_slot_q);

  lkv_ram #(
    .WIDTH (lkv_pkg::KEY_W),
    .DEPTH (lkv_pkg::ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (tgt_slot),
    .wdata_i (key_q),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (key_rdata)
  );

  lkv_ram #(
    .WIDTH (lkv_pkg::VAL_W),
    .DEPTH (lkv_pkg::ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (tgt_slot),
    .wdata_i (val_q),
    .raddr_i (hit_slot_q),
    .rdata_o (val_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkv_pkg::ST_IDLE: begin
        if (req_fire) state_d = lkv_pkg::ST_SCAN;
      end
      lkv_pkg::ST_SCAN: begin
        if (scan_last) state_d = lkv_pkg::ST_DECIDE;
      end
      lkv_pkg::ST_DECIDE: state_d = lkv_pkg::ST_UPDATE;
      lkv_pkg::ST_UPDATE: state_d = lkv_pkg::ST_DONE;
      lkv_pkg::ST_DONE: begin
        if (rsp_free) state_d = lkv_pkg::ST_IDLE;
      end
      default: state_d = lkv_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_i.ready = 1'b0;
    key_we      = 1'b0;
    val_we      = 1'b0;
    do_update   = 1'b0;
    load_rsp    = 1'b0;
    unique case (state_q)
      lkv_pkg::ST_IDLE: req_i.ready = 1'b1;
      lkv_pkg::ST_SCAN, lkv_pkg::ST_DECIDE: ;
      lkv_pkg::ST_UPDATE: begin
        do_update = 1'b1;
        key_we    = (op_q == lkv_pkg::OP_PUT) && !found_q;
        val_we    = (op_q == lkv_pkg::OP_PUT);
      end
      lkv_pkg::ST_DONE: load_rsp = rsp_free;
      default: ;
    endcase
  end

  // scan datapath: one key compare and one rank compare per cycle
  always_comb begin
    logic cur_valid;
    logic match;
    cnt_d        = cnt_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    found_d      = found_q;
    hit_slot_d   = hit_slot_q;
    any_d        = any_q;
    best_d       = best_q;
    old_slot_d   = old_slot_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    cur_valid    = valid_q[cmp_idx_q];
    match        = cur_valid && (key_rdata == key_q);

    if (req_fire) begin
      cnt_d        = '0;
      found_d      = 1'b0;
      any_d        = 1'b0;
      free_found_d = 1'b0;
    end else if (state_q == lkv_pkg::ST_SCAN) begin
      if (!scan_last) begin
        cmp_vld_d = 1'b1;
        cmp_idx_d = cnt_q[IDX_W-1:0];
        cnt_d     = cnt_q + CNT_W'(1);
      end
      if (cmp_vld_q) begin
        if (match && !found_q) begin
          found_d    = 1'b1;
          hit_slot_d = cmp_idx_q;
        end
        if (cur_valid && (!any_q || (rank_q[cmp_idx_q] > best_q))) begin
          any_d      = 1'b1;
          best_d     = rank_q[cmp_idx_q];
          old_slot_d = cmp_idx_q;
        end
        if (!cur_valid && !free_found_q) begin
          free_found_d = 1'b1;
          free_slot_d  = cmp_idx_q;
        end
      end
    end
  end

  // state update and response
  always_comb begin
    logic [RANK_W-1:0] tgt_rank;
    logic              insert;
    valid_d     = valid_q;
    occ_d       = occ_q;
    rank_d      = rank_q;
    pend_hit_d  = pend_hit_q;
    pend_val_d  = pend_val_q;
    rsp_valid_d = rsp_valid_q;
    rsp_hit_d   = rsp_hit_q;
    rsp_val_d   = rsp_val_q;
    tgt_rank    = rank_q[tgt_slot];
    insert      = (op_q == lkv_pkg::OP_PUT) && !found_q && !evict;

    if (do_update) begin
      pend_hit_d = found_q;
      if (op_q == lkv_pkg::OP_GET) begin
        pend_val_d = found_q ? val_rdata : lkv_pkg::MISS_VALUE;
      end else begin
        pend_val_d = '0;
      end
      if (insert) begin
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
          if (valid_q[i]) rank_d[i] = rank_q[i] + RANK_W'(1);
        end
        rank_d[tgt_slot]  = '0;
        valid_d[tgt_slot] = 1'b1;
        occ_d             = occ_q + CNT_W'(1);
      end else if (found_q || (op_q == lkv_pkg::OP_PUT)) begin
        // move to front: younger entries age by one
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
          if (valid_q[i] && (IDX_W'(i) != tgt_slot) && (rank_q[i] < tgt_rank)) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end
        end
        rank_d[tgt_slot] = '0;
      end
    end

    if (rsp_o.valid && rsp_o.ready) rsp_valid_d = 1'b0;
    if (load_rsp) begin
      rsp_valid_d = 1'b1;
      rsp_hit_d   = pend_hit_q;
      rsp_val_d   = pend_val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lkv_pkg::ST_IDLE;
      cap_q        <= lkv_pkg::CAP_RESET;
      occ_q        <= '0;
      valid_q      <= '0;
      rank_q       <= '{default: '0};
      cnt_q        <= '0;
      cmp_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      any_q        <= 1'b0;
      free_found_q <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_i.valid && cfg_i.ready) cap_q <= cfg_i.data;
      occ_q        <= occ_d;
      valid_q      <= valid_d;
      rank_q       <= rank_d;
      cnt_q        <= cnt_d;
      cmp_vld_q    <= cmp_vld_d;
      found_q      <= found_d;
      any_q        <= any_d;
      free_found_q <= free_found_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q  <= req_i.operation;
      key_q <= req_i.key;
      val_q <= req_i.value;
    end
    cmp_idx_q   <= cmp_idx_d;
    hit_slot_q  <= hit_slot_d;
    best_q      <= best_d;
    old_slot_q  <= old_slot_d;
    free_slot_q <= free_slot_d;
    pend_hit_q  <= pend_hit_d;
    pend_val_q  <= pend_val_d;
    rsp_hit_q   <= rsp_hit_d;
    rsp_val_q   <= rsp_val_d;
  end

  assign cfg_i.ready      = 1'b1;
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hit        = rsp_hit_q;
  assign rsp_o.read_value = rsp_val_q;

  a_occ_matches_valid: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == occ_q
  ) else $error("occupancy does not match valid bits");

  a_insert_has_free: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkv_pkg::ST_UPDATE && op_q == lkv_pkg::OP_PUT && !found_q && !evict)
      |-> free_found_q
  ) else $error("insert without a free slot");

  a_load_shows_rsp: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkv_pkg::ST_DONE && rsp_free) |=> (rsp_o.valid && state_q == lkv_pkg::ST_IDLE)
  ) else $error("response not presented after completion");

endmodule

// ===== hdl/lkv_ram.sv =====
`timescale 1ns / 1ps

module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/lru_key_value_cache_tb.sv =====
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 250;
  localparam int KEY_POOL    = 24;
  localparam int PHASE_WORDS = 100;
  localparam int PHASES      = 6;
  localparam int SETTLE_WAIT = lkv_pkg::ENTRIES + 10;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                      hit;
    logic [lkv_pkg::VAL_W-1:0] read_value;
  } lookup_result_t;

  class lru_scoreboard;
    logic [lkv_pkg::CAP_W-1:0] capacity;
    logic [lkv_pkg::KEY_W-1:0] slot_key[lkv_pkg::ENTRIES];
    logic [lkv_pkg::VAL_W-1:0] slot_value[lkv_pkg::ENTRIES];
    bit                        slot_valid[lkv_pkg::ENTRIES];
    int unsigned               slot_rank[lkv_pkg::ENTRIES];
    int unsigned               occupancy;
    lookup_result_t            pending_lookups[$];
    int                        mismatches;

    function new();
      capacity   = lkv_pkg::CAP_RESET;
      occupancy  = 0;
      mismatches = 0;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_rank[i]  = 0;
      end
    endfunction

    function void set_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int pending();
      return pending_lookups.size();
    endfunction

    // slot s becomes most recent, younger valid entries age by one
    function void promote(int s);
      int unsigned r;
      r = slot_rank[s];
      for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
      slot_rank[s] = 0;
    endfunction

    function lookup_result_t lookup_and_update(logic op, logic [lkv_pkg::KEY_W-1:0] key,
                                               logic [lkv_pkg::VAL_W-1:0] value);
      lookup_result_t res;
      int             slot;
      int unsigned    limit;
      slot = -1;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        if (slot < 0 && slot_valid[i] && slot_key[i] == key) slot = i;
      res.hit        = (slot >= 0);
      res.read_value = '0;
      if (op == lkv_pkg::OP_GET) begin
        if (slot >= 0) begin
          res.read_value = slot_value[slot];
          promote(slot);
        end else begin
          res.read_value = lkv_pkg::MISS_VALUE;
        end
        return res;
      end
      if (slot >= 0) begin
        slot_value[slot] = value;
        promote(slot);
        return res;
      end
      // zero acts as one, anything above the depth saturates
      limit = (capacity == 0) ? 1 :
              ((capacity > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : capacity);
      if (occupancy >= limit && occupancy > 0) begin
        // reuse the slot of the oldest entry, occupancy unchanged
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
          if (slot_valid[i] && (slot < 0 || slot_rank[i] > slot_rank[slot])) slot = i;
        slot_key[slot]   = key;
        slot_value[slot] = value;
        promote(slot);
      end else begin
        for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--)
          if (!slot_valid[i]) slot = i;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
          if (slot_valid[i]) slot_rank[i]++;
        slot_valid[slot] = 1'b1;
        slot_key[slot]   = key;
        slot_value[slot] = value;
        slot_rank[slot]  = 0;
        occupancy++;
      end
      return res;
    endfunction

    function void note_request(logic op, logic [lkv_pkg::KEY_W-1:0] key,
                               logic [lkv_pkg::VAL_W-1:0] value);
      pending_lookups.push_back(lookup_and_update(op, key, value));
    endfunction

    function void report(string what, logic [lkv_pkg::VAL_W-1:0] want,
                         logic [lkv_pkg::VAL_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %s: expected %h got %h", what, want, got);
    endfunction

    function void check_response(logic hit, logic [lkv_pkg::VAL_W-1:0] read_value);
      lookup_result_t want;
      if (pending_lookups.size() == 0) begin
        report("unexpected word, read_value", '0, read_value);
        return;
      end
      want = pending_lookups.pop_front();
      if (hit !== want.hit)
        report("hit", lkv_pkg::VAL_W'(want.hit), lkv_pkg::VAL_W'(hit));
      if (read_value !== want.read_value) report("read_value", want.read_value, read_value);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lkv_req_if req ();
  lkv_rsp_if rsp ();
  lkv_cfg_if cfg ();

  lru_key_value_cache u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  lru_scoreboard board = new();
  int            req_idle_pct = 0;
  int            rsp_idle_pct = 0;
  logic          rsp_hold_go  = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // response side: random stalls plus one long hold-off on request
  initial begin : rsp_side
    int hold_left;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready) board.check_response(rsp.hit, rsp.read_value);
      if (rsp_hold_go) begin
        hold_left   = LONG_HOLD;
        rsp_hold_go = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= !(rsp_idle_pct > 0 && $urandom_range(99) < rsp_idle_pct);
      end
    end
  end

  // returns at the accept edge; valid stays up for the next call to reuse
  task automatic send_request(logic op, logic [lkv_pkg::KEY_W-1:0] key,
                              logic [lkv_pkg::VAL_W-1:0] value);
    while (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.key       <= key;
    req.value     <= value;
    do @(posedge clk_i); while (!req.ready);
    board.note_request(op, key, value);
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
    cfg.valid <= 1'b1;
    cfg.data  <= cap;
    do @(posedge clk_i); while (!cfg.ready);
    board.set_capacity(cap);
    cfg.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [lkv_pkg::KEY_W-1:0] pool[KEY_POOL];
    logic [lkv_pkg::CAP_W-1:0] phase_cap[PHASES];
    logic [lkv_pkg::KEY_W-1:0] key;
    logic                      op;

    phase_cap = '{5'd31, 5'd16, 5'd5, 5'd1, 5'd0, 5'd9};

    rst_ni        <= 1'b0;
    req.valid     <= 1'b0;
    req.operation <= lkv_pkg::OP_GET;
    req.key       <= '0;
    req.value     <= '0;
    cfg.valid     <= 1'b0;
    cfg.data      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // directed: empty store, key extremes, update, stored -1 vs miss
    send_request(lkv_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(lkv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(lkv_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(lkv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h1234_5678);
    send_request(lkv_pkg::OP_PUT, 32'h8000_0000, 32'h1234_5678);
    send_request(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(lkv_pkg::OP_GET, 32'h5555_5555, 32'h0000_0000);
    settle();

    // capacity below current occupancy: evictions reuse slots
    write_capacity(5'd2);
    send_request(lkv_pkg::OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(lkv_pkg::OP_PUT, 32'h0000_0001, 32'h0000_0001);
    send_request(lkv_pkg::OP_GET, 32'hAAAA_AAAA, 32'h0000_0000);
    settle();

    write_capacity(5'd0);
    send_request(lkv_pkg::OP_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    send_request(lkv_pkg::OP_GET, 32'h0F0F_0F0F, 32'h0000_0000);
    send_request(lkv_pkg::OP_PUT, 32'h0F0F_0F0F, 32'h0000_0000);
    send_request(lkv_pkg::OP_GET, 32'hF0F0_F0F0, 32'h0000_0000);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      if (p < 2) begin
        req_idle_pct = 14;
        rsp_idle_pct = 80;
      end else if (p < 4) begin
        req_idle_pct = 80;
        rsp_idle_pct = 14;
      end else begin
        req_idle_pct = 0;
        rsp_idle_pct = 0;
      end
      for (int k = 0; k < KEY_POOL; k++) pool[k] = $urandom;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 2 && n == 20) rsp_hold_go = 1'b1;
        if (p == 3 && n == 50) settle();
        op  = 1'($urandom_range(1));
        key = ($urandom_range(99) < 88) ? pool[$urandom_range(KEY_POOL - 1)] : $urandom;
        send_request(op, key, $urandom);
      end
      settle();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
